[rtl/tmem_texel_decode_convert_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the texture memory texel decoder
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TMEM_TEXEL_DECODE_CONVERT_ASSERT_SVH
`define TMEM_TEXEL_DECODE_CONVERT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/ttdc_pkg.sv]
// ----------------------------------------------------------------------------
// Texel decoder package
// Shared types and constants for the texel fetch and decode block.
// ----------------------------------------------------------------------------
`default_nettype none
package ttdc_pkg;
  localparam logic [2:0] FMT_RGBA = 3'd0;
  localparam logic [2:0] FMT_IA   = 3'd3;
  localparam logic [1:0] SIZE_4   = 2'd0;
  localparam logic [1:0] SIZE_8   = 2'd1;
  localparam logic [1:0] SIZE_16  = 2'd2;
  localparam logic [1:0] SIZE_32  = 2'd3;
  localparam logic [1:0] PAL_NONE = 2'd0;
  localparam logic [1:0] PAL_IA16 = 2'd2;
  localparam logic [11:0] PAL_BASE  = 12'h800;
  localparam logic [11:0] MASK_FULL = 12'hFFF;
  localparam logic [11:0] MASK_HALF = 12'h7FF;

  localparam logic [2:0] REG_FORMAT  = 3'd0;
  localparam logic [2:0] REG_SIZE    = 3'd1;
  localparam logic [2:0] REG_PALMODE = 3'd2;
  localparam logic [2:0] REG_PALSEL  = 3'd3;
  localparam logic [2:0] REG_START   = 3'd4;
  localparam logic [2:0] REG_ROW     = 3'd5;

  // Byte fetch slots.
  localparam logic [2:0] SLOT_P0 = 3'd0;
  localparam logic [2:0] SLOT_P1 = 3'd1;
  localparam logic [2:0] SLOT_P2 = 3'd2;
  localparam logic [2:0] SLOT_P3 = 3'd3;
  localparam logic [2:0] SLOT_L0 = 3'd4;
  localparam logic [2:0] SLOT_L1 = 3'd5;

  typedef struct packed {
    logic [2:0] pixel_format;
    logic [1:0] pixel_size;
    logic [1:0] palette_mode;
    logic [3:0] palette_select;
    logic [11:0] texture_start;
    logic [12:0] row_bytes;
  } cfg_t;

  typedef struct packed {
    logic start;       // latch coordinates, begin row division
    logic div_step;    // one quotient bit
    logic rd_issue;    // issue memory read for slot
    logic [2:0] slot;  // slot being read / captured
    logic capture;     // capture read data into slot
    logic finish;      // load output register
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic need32;
  } sts_t;
endpackage
`default_nettype wire

[rtl/ttdc_datapath.sv]
// ----------------------------------------------------------------------------
// Texel decoder datapath
// Address formation with a bit-serial row divider, texture memory, decode.
// ----------------------------------------------------------------------------
`default_nettype none
module ttdc_datapath
  import ttdc_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        wr_en,
  input  wire logic [11:0] wr_addr,
  input  wire logic [7:0]  wr_byte,
  input  wire logic [COORD_BITS-1:0] x_in,
  input  wire logic [COORD_BITS-1:0] y_in,
  output logic [95:0]      result
);
  localparam int AW = COORD_BITS + 14;
  logic [7:0]  mem [4096];
  logic [7:0]  rdata_r;
  logic [COORD_BITS-1:0] x_r;
  logic        odd_row_r;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [12:0] rsize;
  logic [13:0] rs14, t0, t1, t2, t3;
  logic [AW-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic [7:0]  p_r [6];
  logic        is32, use_pal;
  logic [1:0]  shift;
  logic [11:0] amask, rd_addr;
  logic [AW-1:0] xoff, rel, rem_sl, off;
  logic [11:0] fa;
  logic [3:0]  p4;
  logic [11:0] pa;
  logic [7:0]  r, g, b, a;
  logic [15:0] pv;

  assign is32    = cfg.pixel_format == FMT_RGBA && cfg.pixel_size == SIZE_32;
  assign use_pal = cfg.palette_mode != PAL_NONE;
  assign shift   = is32 ? 2'd2 : cfg.pixel_size;
  assign amask   = (is32 || use_pal) ? MASK_HALF : MASK_FULL;
  assign xoff    = (AW'(x_in) << shift) >> 1;
  assign rsize   = (cfg.row_bytes == 13'd0) ? 13'd1 : cfg.row_bytes;
  assign rs14    = {1'b0, rsize};
  assign sts.div_done = dcnt_r == 5'd0;
  assign sts.need32   = !use_pal && cfg.pixel_size == SIZE_32;

  // Shift-and-subtract divider of the texel address by the row size.
  assign rem_sl = {rem_r[AW-2:0], quo_r[AW-1]};
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dcnt_nxt = dcnt_r;
    addr_nxt = addr_r;
    if (cmd.start) begin
      addr_nxt = AW'(y_in) * AW'(rsize) + xoff;
      quo_nxt  = addr_nxt;
      rem_nxt  = '0;
      dcnt_nxt = 5'(AW);
    end else if (cmd.div_step && dcnt_r != 5'd0) begin
      dcnt_nxt = dcnt_r - 5'd1;
      if (rem_sl >= AW'(rsize)) begin
        rem_nxt = rem_sl - AW'(rsize);
        quo_nxt = {quo_r[AW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sl;
        quo_nxt = {quo_r[AW-2:0], 1'b0};
      end
    end
  end

  // Byte address of each slot. The byte offset within its own row is the
  // remainder plus the slot offset, brought back below the row size.
  always_comb begin
    off = '0;
    case (cmd.slot)
      SLOT_P1: off = AW'(1);
      SLOT_P2: off = is32 ? AW'(0) : AW'(2);
      SLOT_P3: off = is32 ? AW'(1) : AW'(3);
      default: off = '0;
    endcase
    rel = addr_r + off;
    t0 = rem_r[13:0] + {12'd0, off[1:0]};
    t1 = (t0 >= rs14) ? t0 - rs14 : t0;
    t2 = (t1 >= rs14) ? t1 - rs14 : t1;
    t3 = (t2 >= rs14) ? t2 - rs14 : t2;
    if (odd_row_r)
      fa = cfg.texture_start + rel[11:0] - t3[11:0] + {t3[11:2] ^ 10'd1, rel[1:0]};
    else
      fa = cfg.texture_start + rel[11:0];
    p4 = x_r[0] ? p_r[0][3:0] : p_r[0][7:4];
    if (cfg.pixel_size == SIZE_4)
      pa = PAL_BASE + {1'b0, cfg.palette_select, 7'd0} + {5'd0, p4, 3'd0};
    else
      pa = PAL_BASE + {1'b0, p_r[0], 3'd0};
    case (cmd.slot)
      SLOT_L0: rd_addr = pa;
      SLOT_L1: rd_addr = pa + 12'd1;
      SLOT_P2, SLOT_P3:
        rd_addr = (fa & amask) | (is32 ? PAL_BASE : 12'd0);
      default: rd_addr = fa & amask;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_byte;
    if (cmd.rd_issue) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else begin
      dcnt_r <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    addr_r <= addr_nxt;
    if (cmd.start) begin
      x_r <= x_in;
      odd_row_r <= y_in[0];
    end
    if (cmd.capture) p_r[cmd.slot] <= rdata_r;
  end

  function automatic logic [7:0] ext5(input logic [4:0] v);
    ext5 = {v, v[4:2]};
  endfunction

  always_comb begin
    logic [7:0] ib;
    ib = {4'd0, p4 & 4'hE};
    r = 8'd0; g = 8'd0; b = 8'd0; a = 8'hFF;
    pv = {p_r[4], p_r[5]};
    if (use_pal) begin
      if (cfg.palette_mode == PAL_IA16) begin
        r = pv[15:8]; g = pv[15:8]; b = pv[15:8]; a = pv[7:0];
      end else begin
        r = ext5(pv[15:11]); g = ext5(pv[10:6]); b = ext5(pv[5:1]);
        a = pv[0] ? 8'hFF : 8'h00;
      end
    end else begin
      case (cfg.pixel_size)
        SIZE_4: begin
          if (cfg.pixel_format == FMT_IA) begin
            r = (ib << 4) | (ib << 1) | (ib >> 2); g = r; b = r;
            a = p4[0] ? 8'hFF : 8'h00;
          end else begin
            r = {p4, p4}; g = r; b = r; a = r;
          end
        end
        SIZE_8: begin
          if (cfg.pixel_format == FMT_IA) begin
            r = {p_r[0][7:4], p_r[0][7:4]}; g = r; b = r;
            a = {p_r[0][3:0], p_r[0][3:0]};
          end else begin
            r = p_r[0]; g = r; b = r; a = r;
          end
        end
        SIZE_16: begin
          pv = {p_r[0], p_r[1]};
          if (cfg.pixel_format == FMT_RGBA) begin
            r = ext5(pv[15:11]); g = ext5(pv[10:6]); b = ext5(pv[5:1]);
            a = pv[0] ? 8'hFF : 8'h00;
          end else if (cfg.pixel_format == FMT_IA) begin
            r = p_r[0]; g = r; b = r; a = p_r[1];
          end else begin
            r = p_r[0]; g = p_r[1]; b = p_r[0]; a = p_r[1];
          end
        end
        default: begin
          if (cfg.pixel_format == FMT_RGBA) begin
            r = p_r[0]; g = p_r[1]; b = p_r[2]; a = p_r[3];
          end else if (x_r[0]) begin
            r = p_r[0]; g = p_r[1]; b = p_r[0]; a = p_r[1];
          end else begin
            r = p_r[2]; g = p_r[3]; b = p_r[2]; a = p_r[3];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish)
      result <= {{a[7:4], r[7:4], g[7:4], b[7:4]},
                 {a[7], r[7:3], g[7:3], b[7:3]},
                 {1'b1, r[7:3], g[7:3], b[7:3]},
                 {r[7:3], g[7:2], b[7:3]},
                 a, b, g, r};
  end
endmodule
`default_nettype wire

[rtl/ttdc_ctrl.sv]
// ----------------------------------------------------------------------------
// Texel decoder controller
// Sequences division, byte reads and the output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module ttdc_ctrl
  import ttdc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic is_fetch,
  input  wire logic use_pal,
  input  wire sts_t sts,
  input  wire logic out_taken,
  output cmd_t      cmd,
  output logic      busy,
  output logic      out_valid
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CAP  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt, slot_r, slot_nxt;
  logic ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    slot_nxt = slot_r;
    ov_nxt = ov_r && !out_taken;
    cmd = '0;
    cmd.slot = slot_r;
    case (state_r)
      S_IDLE: if (in_fire && is_fetch) begin
        cmd.start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          slot_nxt = SLOT_P0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        cmd.capture = 1'b1;
        state_nxt = S_RD;
        case (slot_r)
          SLOT_P0: slot_nxt = use_pal ? SLOT_L0 : SLOT_P1;
          SLOT_P1: if (sts.need32) slot_nxt = SLOT_P2; else state_nxt = S_FIN;
          SLOT_P2: slot_nxt = SLOT_P3;
          SLOT_L0: slot_nxt = SLOT_L1;
          default: state_nxt = S_FIN;
        endcase
      end
      S_FIN: if (!ov_r) begin
        cmd.finish = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = state_r != S_IDLE;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r <= SLOT_P0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r <= slot_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/tmem_texel_decode_convert.sv]
// ----------------------------------------------------------------------------
// Texture memory texel fetch and decode
// Byte-loaded 4 KiB texture memory with texel decode to RGBA8 and 16-bit forms.
// ----------------------------------------------------------------------------
// A write beat stores one byte. A fetch beat is accepted, then a bit-serial
// division of the texel address by the row size runs, then each byte is read
// from the texture memory and captured (two bytes, three with a palette entry,
// four for 32-bit texels), then the output register is loaded, which waits
// while an earlier result is still unaccepted. The input is not ready from the
// acceptance of a fetch until its output register is loaded, so fetches are
// handled one at a time.
`default_nettype none
module tmem_texel_decode_convert
  import ttdc_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: mem_address[11:0], mem_byte[19:12], texel_x, texel_y, zero fill
  input  wire logic [((20+2*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // tuser: operation
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: red, green, blue, alpha, rgb565, xrgb1555, argb1555, argb4444
  output logic [95:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic busy, in_fire, wr;
  logic [2:0] ridx;
  logic [COORD_BITS-1:0] tx, ty;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign tx = in_tdata[20 +: COORD_BITS];
  assign ty = in_tdata[20+COORD_BITS +: COORD_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{3'd0, 2'd0, 2'd0, 4'd0, 12'd0, 13'd8};
    end else if (wr) begin
      case (ridx)
        REG_FORMAT:  cfg_r.pixel_format <= cfg_pwdata[2:0];
        REG_SIZE:    cfg_r.pixel_size <= cfg_pwdata[1:0];
        REG_PALMODE: cfg_r.palette_mode <= cfg_pwdata[1:0];
        REG_PALSEL:  cfg_r.palette_select <= cfg_pwdata[3:0];
        REG_START:   cfg_r.texture_start <= cfg_pwdata[11:0];
        REG_ROW:     cfg_r.row_bytes <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_FORMAT:  cfg_prdata = {29'd0, cfg_r.pixel_format};
      REG_SIZE:    cfg_prdata = {30'd0, cfg_r.pixel_size};
      REG_PALMODE: cfg_prdata = {30'd0, cfg_r.palette_mode};
      REG_PALSEL:  cfg_prdata = {28'd0, cfg_r.palette_select};
      REG_START:   cfg_prdata = {20'd0, cfg_r.texture_start};
      REG_ROW:     cfg_prdata = {19'd0, cfg_r.row_bytes};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  ttdc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .is_fetch(in_tuser),
    .use_pal(cfg_r.palette_mode != PAL_NONE), .sts(sts),
    .out_taken(out_tready), .cmd(cmd), .busy(busy), .out_valid(out_tvalid)
  );

  ttdc_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .cmd(cmd), .sts(sts),
    .wr_en(in_fire && !in_tuser), .wr_addr(in_tdata[11:0]),
    .wr_byte(in_tdata[19:12]), .x_in(tx), .y_in(ty), .result(out_tdata)
  );

`include "tmem_texel_decode_convert_assert.svh"
  `ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, busy, !in_tready)
  `ASSERT_NEXT(a_fetch_busy, clk, rst_n, in_fire && in_tuser, busy)
  `ASSERT_IMPLY(a_one_cmd, clk, rst_n, cmd.finish, !out_tvalid)
endmodule
`default_nettype wire
